// ===== hw/rtl/cdq_pkg.sv =====
// cdq_pkg: shared sizes, command and status codes, and the entry store request
// type of the circular deque. No dependencies.
`default_nettype none
package cdq_pkg;

  localparam int DEPTH      = 8;
  localparam int DATA_WIDTH = 32;
  localparam int PTR_W      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W      = $clog2(DEPTH + 1);
  localparam int CMD_W      = 3;
  localparam int STAT_W     = 2;
  localparam int WORD_W     = 32;

  localparam logic [CMD_W-1:0] CMD_PUSH_FRONT = 3'd0;
  localparam logic [CMD_W-1:0] CMD_PUSH_BACK  = 3'd1;
  localparam logic [CMD_W-1:0] CMD_POP_FRONT  = 3'd2;
  localparam logic [CMD_W-1:0] CMD_POP_BACK   = 3'd3;
  localparam logic [CMD_W-1:0] CMD_PEEK_FRONT = 3'd4;
  localparam logic [CMD_W-1:0] CMD_PEEK_BACK  = 3'd5;

  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STAT_W-1:0] ST_EMPTY = 2'd2;

  typedef struct packed {
    logic                  wr_en;
    logic [PTR_W-1:0]      wr_addr;
    logic [DATA_WIDTH-1:0] wr_data;
    logic                  rd_en;
    logic [PTR_W-1:0]      rd_addr;
  } mem_req_t;

endpackage
`default_nettype wire

// ===== hw/rtl/cdq_ram.sv =====
// cdq_ram: entry store of the circular deque, one write and one read port,
// read data registered. Depends on cdq_pkg.
`default_nettype none
module cdq_ram (
  input  wire logic                            clk,
  input  wire cdq_pkg::mem_req_t               req,
  output logic      [cdq_pkg::DATA_WIDTH-1:0]  rd_data
);

  logic [cdq_pkg::DATA_WIDTH-1:0] mem [cdq_pkg::DEPTH];
  logic [cdq_pkg::DATA_WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      rd_data_r <= mem[req.rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule
`default_nettype wire

// ===== hw/rtl/circular_deque.sv =====
// circular_deque: top level of a fixed-depth double-ended queue kept in a ring.
// Depends on cdq_pkg and cdq_ram.
//
// Usage:
//   Input channel: drive in_command and in_data_in with start high; the word
//   is taken at a rising edge where start is high and busy is low.
//   Commands: push front, push back, pop front, pop back, peek front,
//   peek back; codes six and seven are no-ops that answer ok.
//   Result channel: every accepted word yields exactly one result, shown on
//   out_data_out and out_status while out_strobe is high for one cycle.
//   The receiver cannot stall; a result must be taken in that cycle.
// Result timing: the result appears in the cycle after the accepting edge (the
//   entry store read data is registered).
// Throughput: one word per cycle while busy is low. Pointers and occupancy update at the
//   accepting edge, so the next command already sees them; a push writes the
//   store at its edge and a following read sees the new entry.
// Reset: rst_n low (synchronous) empties the queue and clears pointers and
//   the result strobe; busy stays high for the reset cycle and drops right
//   after. Entries are not cleared; only occupied entries are ever read.
`default_nettype none
module circular_deque (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            start,
  output logic                                 busy,
  input  wire logic        [cdq_pkg::CMD_W-1:0] in_command,
  input  wire logic signed [31:0]               in_data_in,
  output logic                                 out_strobe,
  output logic signed      [31:0]               out_data_out,
  output logic             [cdq_pkg::STAT_W-1:0] out_status
);

  localparam int PW = cdq_pkg::PTR_W;
  localparam int CW = cdq_pkg::CNT_W;

  // Ring pointer steps, with wrap for any depth.
  function automatic logic [PW-1:0] ptr_next(input logic [PW-1:0] p);
    ptr_next = (p == PW'(cdq_pkg::DEPTH - 1)) ? '0 : p + PW'(1);
  endfunction

  function automatic logic [PW-1:0] ptr_prev(input logic [PW-1:0] p);
    ptr_prev = (p == '0) ? PW'(cdq_pkg::DEPTH - 1) : p - PW'(1);
  endfunction

  logic                          busy_r;
  logic [PW-1:0]                 head_r, head_nxt;
  logic [PW-1:0]                 tail_r, tail_nxt;
  logic [CW-1:0]                 occ_r, occ_nxt;
  logic                          valid_r;
  logic [cdq_pkg::STAT_W-1:0]    status_r, status_nxt;
  logic                          rd_sel_r;
  cdq_pkg::mem_req_t             req;
  logic [cdq_pkg::DATA_WIDTH-1:0] rd_data;
  logic                          accept;
  logic                          is_full, is_empty, is_front;

  assign accept   = start & ~busy_r;
  assign is_full  = (occ_r == CW'(cdq_pkg::DEPTH));
  assign is_empty = (occ_r == '0);
  assign is_front = (in_command == cdq_pkg::CMD_POP_FRONT) ||
                    (in_command == cdq_pkg::CMD_PEEK_FRONT);

  // Decode the command against the current pointers; issue at most one store access.
  always_comb begin
    head_nxt   = head_r;
    tail_nxt   = tail_r;
    occ_nxt    = occ_r;
    status_nxt = cdq_pkg::ST_OK;
    req        = '0;
    req.wr_data = cdq_pkg::DATA_WIDTH'($unsigned(in_data_in));
    if (accept) begin
      case (in_command)
        cdq_pkg::CMD_PUSH_FRONT, cdq_pkg::CMD_PUSH_BACK: begin
          if (is_full) begin
            status_nxt = cdq_pkg::ST_FULL;
          end else if (in_command == cdq_pkg::CMD_PUSH_FRONT) begin
            // Step head back around the ring and write there.
            head_nxt    = ptr_prev(head_r);
            req.wr_en   = 1'b1;
            req.wr_addr = ptr_prev(head_r);
            occ_nxt     = occ_r + CW'(1);
          end else begin
            req.wr_en   = 1'b1;
            req.wr_addr = tail_r;
            tail_nxt    = ptr_next(tail_r);
            occ_nxt     = occ_r + CW'(1);
          end
        end
        cdq_pkg::CMD_POP_FRONT, cdq_pkg::CMD_POP_BACK,
        cdq_pkg::CMD_PEEK_FRONT, cdq_pkg::CMD_PEEK_BACK: begin
          if (is_empty) begin
            status_nxt = cdq_pkg::ST_EMPTY;
          end else begin
            req.rd_en   = 1'b1;
            req.rd_addr = is_front ? head_r : ptr_prev(tail_r);
            if (in_command == cdq_pkg::CMD_POP_FRONT) begin
              head_nxt = ptr_next(head_r);
              occ_nxt  = occ_r - CW'(1);
            end else if (in_command == cdq_pkg::CMD_POP_BACK) begin
              tail_nxt = ptr_prev(tail_r);
              occ_nxt  = occ_r - CW'(1);
            end
          end
        end
        default: begin
          // Unused codes: answer ok with zero, change nothing.
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r   <= 1'b1;
      head_r   <= '0;
      tail_r   <= '0;
      occ_r    <= '0;
      valid_r  <= 1'b0;
      rd_sel_r <= 1'b0;
    end else begin
      busy_r   <= 1'b0;
      head_r   <= head_nxt;
      tail_r   <= tail_nxt;
      occ_r    <= occ_nxt;
      valid_r  <= accept;
      rd_sel_r <= req.rd_en;
    end
  end

  // Hold the status of the last word for its result cycle.
  always_ff @(posedge clk) begin
    status_r <= status_nxt;
  end

  cdq_ram u_ram (
    .clk     (clk),
    .req     (req),
    .rd_data (rd_data)
  );

  assign busy         = busy_r;
  assign out_strobe   = valid_r;
  assign out_status   = status_r;
  // Drop store data unless this result came from a read.
  assign out_data_out = rd_sel_r ? signed'(32'($unsigned(rd_data))) : '0;

`ifndef SYNTHESIS
  a_strobe_follows_accept: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(start && !busy))
    else $error("result strobe without an accepted word");

  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    occ_r <= CW'(cdq_pkg::DEPTH))
    else $error("occupancy beyond depth");

  a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
    ((tail_r >= head_r) ? PW'(tail_r - head_r)
                        : PW'(cdq_pkg::DEPTH - 1) - head_r + tail_r + PW'(1)) ==
    (is_full ? PW'(0) : PW'(occ_r)))
    else $error("head and tail disagree with occupancy");

  a_full_reject: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && is_full && (in_command == cdq_pkg::CMD_PUSH_FRONT ||
     in_command == cdq_pkg::CMD_PUSH_BACK)) |=> (out_status == cdq_pkg::ST_FULL))
    else $error("push on full queue not rejected");
`endif

endmodule
`default_nettype wire

// ===== test/tb_circular_deque.sv =====
// tb_circular_deque: self-checking testbench for the circular deque; a queue-fed
// driver, a result monitor and an in-bench deque model that predicts each result.
// Depends on cdq_pkg and the circular_deque RTL.
`default_nettype none
module tb_circular_deque;

  // Codes six and seven carry no operation; the block answers ok with zero data.
  localparam logic [cdq_pkg::CMD_W-1:0] CMD_SPARE_LO = 3'd6;
  localparam logic [cdq_pkg::CMD_W-1:0] CMD_SPARE_HI = 3'd7;

  localparam int RANDOM_WORDS  = 1200;
  localparam int PHASE_LEN     = 400;   // words per idling phase
  localparam int STALL_LIMIT   = 1000;  // cycles with no handshake before giving up
  localparam int SETTLE_CYCLES = 5;     // slack after the last result is back

  typedef struct {
    logic [cdq_pkg::CMD_W-1:0] cmd;
    logic signed [31:0]        value;
    bit                        drain;  // hold this word until every result is back
  } deque_word_t;

  typedef struct {
    logic signed [31:0]         data;
    logic [cdq_pkg::STAT_W-1:0] status;
  } deque_result_t;

  logic                        clk = 1'b0;
  logic                        rst_n = 1'b0;
  logic                        start = 1'b0;
  logic                        busy;
  logic [cdq_pkg::CMD_W-1:0]   in_command = '0;
  logic signed [31:0]          in_data_in = '0;
  logic                        out_strobe;
  logic signed [31:0]          out_data_out;
  logic [cdq_pkg::STAT_W-1:0]  out_status;

  deque_word_t   pending_words[$];
  deque_result_t awaited_results[$];
  int            mismatches = 0;
  int            words_issued = 0;
  int            quiet_cycles = 0;

  // Model of the ring: only occupied slots are ever read.
  logic [cdq_pkg::DATA_WIDTH-1:0] ring_slot[cdq_pkg::DEPTH];
  logic [cdq_pkg::PTR_W-1:0]      front_idx = '0;
  logic [cdq_pkg::PTR_W-1:0]      back_idx = '0;
  int unsigned                    fill_level = 0;

  circular_deque u_top (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_command   (in_command),
    .in_data_in   (in_data_in),
    .out_strobe   (out_strobe),
    .out_data_out (out_data_out),
    .out_status   (out_status)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic logic [cdq_pkg::PTR_W-1:0] ring_step_back(
    input logic [cdq_pkg::PTR_W-1:0] p);
    return (p == 0) ? cdq_pkg::PTR_W'(cdq_pkg::DEPTH - 1) : p - 1'b1;
  endfunction

  function automatic logic [cdq_pkg::PTR_W-1:0] ring_step_fwd(
    input logic [cdq_pkg::PTR_W-1:0] p);
    return (p == cdq_pkg::PTR_W'(cdq_pkg::DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  // Apply one accepted word to the model and return the result it must produce.
  task automatic deque_execute(input deque_word_t w, output deque_result_t r);
    logic [cdq_pkg::PTR_W-1:0] rd_idx;
    r.data   = '0;
    r.status = cdq_pkg::ST_OK;
    case (w.cmd)
      cdq_pkg::CMD_PUSH_FRONT, cdq_pkg::CMD_PUSH_BACK: begin
        if (fill_level >= cdq_pkg::DEPTH) begin
          r.status = cdq_pkg::ST_FULL;
        end else if (w.cmd == cdq_pkg::CMD_PUSH_FRONT) begin
          front_idx = ring_step_back(front_idx);
          ring_slot[front_idx] = w.value[cdq_pkg::DATA_WIDTH-1:0];
          fill_level++;
        end else begin
          ring_slot[back_idx] = w.value[cdq_pkg::DATA_WIDTH-1:0];
          back_idx = ring_step_fwd(back_idx);
          fill_level++;
        end
      end
      cdq_pkg::CMD_POP_FRONT, cdq_pkg::CMD_POP_BACK,
      cdq_pkg::CMD_PEEK_FRONT, cdq_pkg::CMD_PEEK_BACK: begin
        if (fill_level == 0) begin
          r.status = cdq_pkg::ST_EMPTY;
        end else begin
          rd_idx = (w.cmd == cdq_pkg::CMD_POP_FRONT || w.cmd == cdq_pkg::CMD_PEEK_FRONT) ?
                   front_idx : ring_step_back(back_idx);
          r.data = 32'(ring_slot[rd_idx]);
          if (w.cmd == cdq_pkg::CMD_POP_FRONT) begin
            front_idx = ring_step_fwd(front_idx);
            fill_level--;
          end else if (w.cmd == cdq_pkg::CMD_POP_BACK) begin
            back_idx = rd_idx;
            fill_level--;
          end
        end
      end
      default: ;  // spare codes change nothing
    endcase
  endtask

  task automatic queue_word(input logic [cdq_pkg::CMD_W-1:0] cmd,
                            input logic signed [31:0] value,
                            input bit drain);
    deque_word_t w;
    w.cmd   = cmd;
    w.value = value;
    w.drain = drain;
    pending_words.push_back(w);
  endtask

  // Favor the extremes and sign boundaries, but let every bit toggle.
  function automatic logic signed [31:0] pick_value();
    case ($urandom_range(0, 9))
      0:       return 32'sh8000_0000;
      1:       return 32'sh7fff_ffff;
      2:       return '0;
      3:       return -32'sd1;
      default: return $urandom;
    endcase
  endfunction

  // Driver: present one word at a time; a word moves when start is high and busy low.
  always @(posedge clk) begin
    deque_word_t   w;
    deque_result_t r;
    bit            taken;
    bit            hold_off;
    int            idle_pct;
    taken = rst_n && start && !busy;
    if (taken) begin
      w.cmd   = in_command;
      w.value = in_data_in;
      w.drain = 1'b0;
      deque_execute(w, r);
      awaited_results.push_back(r);
    end
    if (!rst_n) begin
      start <= 1'b0;
    end else if (start && !taken) begin
      // Hold the current word until the block takes it.
    end else if (pending_words.size() == 0) begin
      start <= 1'b0;
    end else begin
      // Sender idling: light, then heavy, then none at all.
      idle_pct = (words_issued < PHASE_LEN) ? 14 : (words_issued < 2 * PHASE_LEN) ? 64 : 0;
      hold_off = ($urandom_range(0, 99) < idle_pct);
      // A drain word waits until the block has answered everything in flight.
      if (pending_words[0].drain && (taken || awaited_results.size() != 0))
        hold_off = 1'b1;
      if (hold_off) begin
        start <= 1'b0;
      end else begin
        w = pending_words.pop_front();
        start      <= 1'b1;
        in_command <= w.cmd;
        in_data_in <= w.value;
        words_issued++;
      end
    end
  end

  // Monitor: every strobe must match the oldest outstanding prediction.
  always @(posedge clk) begin
    deque_result_t want;
    if (rst_n && out_strobe) begin
      if (awaited_results.size() == 0) begin
        mismatches++;
        $display("%0t: result with none outstanding: data_out=%0d status=%0d",
                 $time, out_data_out, out_status);
      end else begin
        want = awaited_results.pop_front();
        if (out_data_out !== want.data) begin
          mismatches++;
          $display("%0t: data_out mismatch: expected %0d, actual %0d",
                   $time, want.data, out_data_out);
        end
        if (out_status !== want.status) begin
          mismatches++;
          $display("%0t: status mismatch: expected %0d, actual %0d",
                   $time, want.status, out_status);
        end
      end
    end
  end

  // Watchdog: end the run if neither side moves a word for too long.
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_strobe) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int                        burst_len;
    int                        push_pct;
    int                        roll;
    logic [cdq_pkg::CMD_W-1:0] cmd;

    // Directed: empty-queue errors, spare codes, a two-element round trip.
    queue_word(cdq_pkg::CMD_POP_FRONT,  32'sd5, 1'b0);
    queue_word(cdq_pkg::CMD_POP_BACK,   32'sd6, 1'b0);
    queue_word(cdq_pkg::CMD_PEEK_FRONT, 32'sd7, 1'b0);
    queue_word(cdq_pkg::CMD_PEEK_BACK,  32'sd8, 1'b0);
    queue_word(CMD_SPARE_LO,            32'sh7fff_ffff, 1'b0);
    queue_word(CMD_SPARE_HI,            32'sh8000_0000, 1'b0);
    queue_word(cdq_pkg::CMD_PUSH_FRONT, 32'sh8000_0000, 1'b0);
    queue_word(cdq_pkg::CMD_PUSH_BACK,  32'sh7fff_ffff, 1'b0);
    queue_word(cdq_pkg::CMD_PEEK_FRONT, '0, 1'b0);
    queue_word(cdq_pkg::CMD_PEEK_BACK,  '0, 1'b0);
    queue_word(cdq_pkg::CMD_POP_FRONT,  '0, 1'b0);
    queue_word(cdq_pkg::CMD_POP_BACK,   '0, 1'b0);  // last element leaves the queue empty
    // Fill to capacity from both ends, then push into a full queue.
    for (int i = 0; i < cdq_pkg::DEPTH; i++)
      queue_word((i % 2) ? cdq_pkg::CMD_PUSH_FRONT : cdq_pkg::CMD_PUSH_BACK,
                 (i % 3 == 0) ? -32'sd1 : $urandom, 1'b0);
    queue_word(cdq_pkg::CMD_PUSH_FRONT, 32'sh1234_5678, 1'b0);
    queue_word(cdq_pkg::CMD_PUSH_BACK,  32'sh0bad_cafe, 1'b0);
    queue_word(cdq_pkg::CMD_PEEK_BACK,  '0, 1'b0);
    queue_word(cdq_pkg::CMD_POP_BACK,   '0, 1'b0);

    // Random: bursts that lean toward filling, draining or neither, so the ring
    // wraps and hits both the full and the empty edge many times.
    for (int n = 0; n < RANDOM_WORDS; ) begin
      burst_len = $urandom_range(4, 40);
      case ($urandom_range(0, 2))
        0:       push_pct = 75;
        1:       push_pct = 25;
        default: push_pct = 50;
      endcase
      for (int k = 0; k < burst_len && n < RANDOM_WORDS; k++, n++) begin
        roll = $urandom_range(0, 99);
        if (roll < 3)
          cmd = $urandom_range(0, 1) ? CMD_SPARE_HI : CMD_SPARE_LO;
        else if ($urandom_range(0, 99) < push_pct)
          cmd = $urandom_range(0, 1) ? cdq_pkg::CMD_PUSH_BACK : cdq_pkg::CMD_PUSH_FRONT;
        else
          case ($urandom_range(0, 3))
            0:       cmd = cdq_pkg::CMD_POP_FRONT;
            1:       cmd = cdq_pkg::CMD_POP_BACK;
            2:       cmd = cdq_pkg::CMD_PEEK_FRONT;
            default: cmd = cdq_pkg::CMD_PEEK_BACK;
          endcase
        // Drain ahead of the first random word and now and then afterwards.
        queue_word(cmd, pick_value(), (n == 0) || ($urandom_range(0, 149) == 0));
      end
    end

    // Hold reset, then release it for good.
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    do @(posedge clk);
    while (pending_words.size() != 0 || start || awaited_results.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (mismatches == 0 && awaited_results.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      if (awaited_results.size() != 0)
        $display("%0t: %0d results never arrived", $time, awaited_results.size());
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
`default_nettype wire
